### rtl/point_blob_crc_deframer_top_defines.svh
// Assertion macros for the deframer RTL.
`ifndef POINT_BLOB_CRC_DEFRAMER_TOP_DEFINES_SVH
`define POINT_BLOB_CRC_DEFRAMER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PBCD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pbcd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PBCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pbcd assertion failed");

`endif

### rtl/pbcd_pkg.sv
package pbcd_pkg;

    localparam int unsigned COUNTER_BITS_DEF = 16;
    localparam int unsigned LIMIT_BITS       = 11;
    localparam int unsigned STATUS_BITS      = 3;
    localparam int unsigned OUT_DATA_BITS    = 112;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;
    localparam logic [LIMIT_BITS-1:0] DEFAULT_LIMIT = 11'd500;
    localparam logic [35:0] MIN_BLOB = 36'd8;

    localparam logic [STATUS_BITS-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_TOO_SHORT = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_SIZE      = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_BAD_COUNT = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_CRC       = 3'd4;

    localparam logic KIND_POINT  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic                   kind;
        logic [LIMIT_BITS-1:0]  point_index;
        logic [31:0]            x_bits;
        logic [31:0]            y_bits;
        logic [STATUS_BITS-1:0] status;
        logic [31:0]            point_total;
    } t_result;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### rtl/point_blob_crc_deframer_top.sv
// A result item is held in the input register and then in the output register; the frame
// logic between them is combinational, and a full output register stalls the input.
// Throughput: one byte item per cycle while the output is not stalled, with a byte-wide CRC update per item.
// The input register can take one new item while a result waits to be taken.
// Reset is synchronous and active low; it clears the frame state at once and
// sets the point limit to 500, with no clearing pass.
module point_blob_crc_deframer_top
    import pbcd_pkg::*;
#(
    parameter int unsigned COUNTER_BITS = COUNTER_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [7:0]               s_axis_tdata,   // data_byte
    input  logic                     s_axis_tlast,   // last_byte
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // point_index[10:0], x_bits[42:11], y_bits[74:43], status[77:75],
    // point_total[109:78], zero fill[111:110]
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
    output logic                     m_axis_tuser,   // result_kind
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [LIMIT_BITS-1:0]    i_cfg_data      // point_limit
);

    logic [LIMIT_BITS-1:0] r_point_limit;
    logic     in_valid;
    t_in_item in_item;
    t_in_item s_item;
    logic     out_free;
    logic     adv;
    logic     res_valid;
    t_result  res;
    t_result  out_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_limit <= DEFAULT_LIMIT;
        end else if (i_cfg_valid) begin
            r_point_limit <= i_cfg_data;
        end
    end

    assign s_item.data = s_axis_tdata;
    assign s_item.last = s_axis_tlast;
    assign adv = in_valid && out_free;

    pbcd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_item  (s_item),
        .o_ready (s_axis_tready),
        .i_take  (adv),
        .o_valid (in_valid),
        .o_item  (in_item)
    );

    pbcd_frame #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (adv),
        .i_item      (in_item),
        .i_limit     (r_point_limit),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    pbcd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_res   (res),
        .o_free  (out_free),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (out_res)
    );

    assign m_axis_tuser = out_res.kind;
    assign m_axis_tdata = {2'b00, out_res.point_total, out_res.status,
                           out_res.y_bits, out_res.x_bits, out_res.point_index};

endmodule

### rtl/pbcd_in_stage.sv
module pbcd_in_stage
    import pbcd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_item i_item,
    output logic     o_ready,
    input  logic     i_take,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

### rtl/pbcd_frame.sv
`include "point_blob_crc_deframer_top_defines.svh"

module pbcd_frame
    import pbcd_pkg::*;
#(
    parameter int unsigned COUNTER_BITS = COUNTER_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  t_in_item              i_item,
    input  logic [LIMIT_BITS-1:0] i_limit,
    output logic                  o_res_valid,
    output t_result               o_res
);

    logic [COUNTER_BITS-1:0] r_cnt, n_cnt;
    logic [31:0] r_count, n_count;
    logic [31:0] r_crc, n_crc;
    logic [31:0] r_tail, n_tail;
    logic [31:0] r_x, n_x;
    logic [31:0] r_y, n_y;
    logic        step_open;
    logic        point_out;

    always_comb begin
        logic [COUNTER_BITS-1:0] pos;
        logic [COUNTER_BITS-1:0] off;
        logic [31:0]             idx;
        logic [2:0]              lane;
        logic                    sat;
        logic                    ok_cur;
        logic                    ok_new;
        logic [35:0]             size;
        logic [35:0]             expected;
        logic [STATUS_BITS-1:0]  st;

        n_cnt   = r_cnt;
        n_count = r_count;
        n_crc   = r_crc;
        n_tail  = r_tail;
        n_x     = r_x;
        n_y     = r_y;
        o_res_valid = 1'b0;
        o_res       = '0;
        ok_new   = 1'b0;
        size     = '0;
        expected = '0;
        st       = ST_OK;

        pos  = r_cnt;
        sat  = &r_cnt;
        off  = pos - COUNTER_BITS'(4);
        idx  = 32'(off) >> 3;
        lane = off[2:0];
        ok_cur = (r_count != 32'd0) && (r_count <= 32'(i_limit));

        if (i_valid) begin
            if (pos >= COUNTER_BITS'(4)) begin
                n_crc = crc_byte(r_crc, r_tail[7:0]);
            end
            n_tail = {i_item.data, r_tail[31:8]};

            if (!sat) begin
                if (pos < COUNTER_BITS'(4)) begin
                    n_count[{pos[1:0], 3'b000} +: 8] = i_item.data;
                end else begin
                    if (!lane[2]) begin
                        n_x[{lane[1:0], 3'b000} +: 8] = i_item.data;
                    end else begin
                        n_y[{lane[1:0], 3'b000} +: 8] = i_item.data;
                    end
                    if ((lane == 3'd7) && (idx < r_count) && ok_cur) begin
                        o_res_valid       = 1'b1;
                        o_res.kind        = KIND_POINT;
                        o_res.point_index = idx[LIMIT_BITS-1:0];
                        o_res.x_bits      = n_x;
                        o_res.y_bits      = n_y;
                        o_res.status      = ST_OK;
                        o_res.point_total = n_count;
                    end
                end
                n_cnt = pos + COUNTER_BITS'(1);
            end

            if (i_item.last) begin
                ok_new   = (n_count != 32'd0) && (n_count <= 32'(i_limit));
                size     = 36'(n_cnt);
                expected = {1'b0, n_count, 3'b000} + MIN_BLOB;
                priority if (size < MIN_BLOB) begin
                    st = ST_TOO_SHORT;
                end else if ((size != expected) || (&n_cnt)) begin
                    st = ST_SIZE;
                end else if (!ok_new) begin
                    st = ST_BAD_COUNT;
                end else if ((n_crc ^ CRC_ONES) != n_tail) begin
                    st = ST_CRC;
                end else begin
                    st = ST_OK;
                end
                o_res_valid       = 1'b1;
                o_res.kind        = KIND_STATUS;
                o_res.point_index = '0;
                o_res.x_bits      = '0;
                o_res.y_bits      = '0;
                o_res.status      = st;
                o_res.point_total = n_count;

                n_cnt   = '0;
                n_count = '0;
                n_crc   = CRC_ONES;
                n_tail  = '0;
                n_x     = '0;
                n_y     = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_count <= '0;
            r_crc   <= CRC_ONES;
            r_tail  <= '0;
            r_x     <= '0;
            r_y     <= '0;
        end else begin
            r_cnt   <= n_cnt;
            r_count <= n_count;
            r_crc   <= n_crc;
            r_tail  <= n_tail;
            r_x     <= n_x;
            r_y     <= n_y;
        end
    end

    assign step_open = i_valid && !i_item.last && !(&r_cnt);
    assign point_out = o_res_valid && (o_res.kind == KIND_POINT);

    `PBCD_ASSERT_NEXT(a_clear_after_last, i_valid && i_item.last, r_cnt == '0 && r_crc == CRC_ONES)
    `PBCD_ASSERT_NEXT(a_count_steps, step_open, r_cnt == $past(r_cnt) + COUNTER_BITS'(1))
    `PBCD_ASSERT_SAME(a_point_needs_count, point_out, o_res.point_total > 32'(o_res.point_index))

endmodule

### rtl/pbcd_out_stage.sv
module pbcd_out_stage
    import pbcd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_result i_res,
    output logic    o_free,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_valid) begin
            r_res <= i_res;
        end
    end

endmodule
